// ===== rtl/mmt_pkg.sv =====
// Package of shared constants, opcodes and types for the matrix multiply core.
package mmt_pkg;

	localparam int DIM_DEF = 4;
	localparam int IDX_W = 4;
	localparam int VAL_W = 32;
	localparam int POS_W = 2;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W = PROD_W + 4;
	localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MUL    = 2'd2,
		OP_XFORM  = 2'd3
	} opcode_t;

	// Word handed from one cell of the chain to the next.
	typedef struct packed {
		logic                    vld;
		logic                    last;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic signed [ACC_W-1:0] acc;
	} chain_word_t;

endpackage

// ===== rtl/mmt_stream_if.sv =====
// Valid/ready stream interfaces for command words and result words.
interface mmt_cmd_if;
	import mmt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [IDX_W-1:0]        elem_index;
	logic signed [VAL_W-1:0] elem_value;
	modport source (output valid, opcode, elem_index, elem_value, input ready);
	modport sink (input valid, opcode, elem_index, elem_value, output ready);
endinterface

interface mmt_res_if;
	import mmt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        out_row;
	logic [POS_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    out_last;
	modport source (output valid, out_row, out_col, out_value, out_last, input ready);
	modport sink (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ===== rtl/mmt_mac_cell.sv =====
// One multiply-accumulate cell of the dot-product chain.
module mmt_mac_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  mmt_pkg::chain_word_t          word_in,
	input  logic signed [mmt_pkg::VAL_W-1:0] a_val,
	input  logic signed [mmt_pkg::VAL_W-1:0] b_val,
	output mmt_pkg::chain_word_t          word_out
);
	import mmt_pkg::*;

	logic signed [PROD_W-1:0] prod;
	assign prod = PROD_W'(a_val) * PROD_W'(b_val);

	// Add this cell's product and pass the word on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_out <= '0;
		end else if (adv) begin
			word_out.vld  <= word_in.vld;
			word_out.last <= word_in.last;
			word_out.row  <= word_in.row;
			word_out.col  <= word_in.col;
			word_out.acc  <= word_in.acc + ACC_W'(prod);
		end
	end
endmodule

// ===== rtl/matrix4x4_multiply_transform_core.sv =====
// Top level of the fixed-point 4x4 matrix multiply and transform core.
// Usage:
//  - cmd channel: one word per command. Opcode 0 or 1 loads one element of A
//    or B (row-major index, values in Q16.16); an index past the end is
//    dropped. Opcode 2 streams all DIM*DIM elements of A*B, opcode 3 streams
//    the DIM elements of A times column 0 of B.
//  - res channel: row, column, saturated Q16.16 value, last flag per word.
// A run issues one dot product per cycle, while the output register can
// take a word, into a chain of DIM multiply-accumulate cells, one product
// per cell; each result passes through the DIM cells and then the output
// register.
// A new command is taken once the previous run's last word has left the chain.
// The chain advances only while the output register can take a word, so a
// stalled receiver freezes the whole chain without loss.
// Reset sets both matrices to identity and empties the chain.
module matrix4x4_multiply_transform_core (
	input logic clk,
	input logic arst_n,
	mmt_cmd_if.sink   cmd,
	mmt_res_if.source res
);
	import mmt_pkg::*;

	localparam int DIM = DIM_DEF;
	localparam int N = DIM * DIM;
	localparam int CW = $clog2(DIM);
	localparam int EW = $clog2(N);

	logic signed [VAL_W-1:0] mat_a_q [N];
	logic signed [VAL_W-1:0] mat_b_q [N];

	logic            busy_q;
	logic            issuing_q;
	logic            xform_q;
	logic [CW-1:0]   r_q, c_q;
	logic            adv;
	chain_word_t     chain [DIM+1];

	logic cmd_fire;
	assign cmd.ready = !busy_q;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Matrix storage with identity reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				mat_a_q[i] <= (i / DIM == i % DIM) ? ONE_Q16 : '0;
				mat_b_q[i] <= (i / DIM == i % DIM) ? ONE_Q16 : '0;
			end
		end else if (cmd_fire && ({1'b0, cmd.elem_index} < (IDX_W+1)'(N))) begin
			if (cmd.opcode == OP_LOAD_A) begin
				mat_a_q[cmd.elem_index[EW-1:0]] <= cmd.elem_value;
			end else if (cmd.opcode == OP_LOAD_B) begin
				mat_b_q[cmd.elem_index[EW-1:0]] <= cmd.elem_value;
			end
		end
	end

	// Output register and chain advance.
	logic        ovld_q;
	chain_word_t tail;
	assign tail = chain[DIM];
	assign adv  = !ovld_q || res.ready;

	logic last_issue;
	assign last_issue = (r_q == CW'(DIM-1)) && (xform_q || c_q == CW'(DIM-1));

	// Run sequencer: issues one element per advancing cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			xform_q   <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
		end else if (cmd_fire && (cmd.opcode == OP_MUL || cmd.opcode == OP_XFORM)) begin
			busy_q    <= 1'b1;
			issuing_q <= 1'b1;
			xform_q   <= (cmd.opcode == OP_XFORM);
			r_q       <= '0;
			c_q       <= '0;
		end else if (busy_q && adv) begin
			if (issuing_q) begin
				if (last_issue) begin
					issuing_q <= 1'b0;
				end else if (xform_q || c_q == CW'(DIM-1)) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end else if (tail.vld && tail.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign chain[0].vld  = issuing_q;
	assign chain[0].last = last_issue;
	assign chain[0].row  = POS_W'(r_q);
	assign chain[0].col  = POS_W'(c_q);
	assign chain[0].acc  = '0;

	// Operand delay: row and column indices follow each issue down the chain.
	logic [CW-1:0] rd_q [DIM];
	logic [CW-1:0] cd_q [DIM];
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q[0] <= r_q;
			cd_q[0] <= xform_q ? '0 : c_q;
			for (int k = 1; k < DIM; k++) begin
				rd_q[k] <= rd_q[k-1];
				cd_q[k] <= cd_q[k-1];
			end
		end
	end

	// Row of cells, one product term each.
	for (genvar k = 0; k < DIM; k++) begin : g_cell
		logic signed [VAL_W-1:0] a_op, b_op;
		assign a_op = (k == 0) ? mat_a_q[EW'(r_q) * EW'(DIM) + EW'(k)]
			: mat_a_q[EW'(rd_q[(k == 0) ? 0 : k-1]) * EW'(DIM) + EW'(k)];
		assign b_op = (k == 0) ? mat_b_q[EW'(k) * EW'(DIM) + EW'(xform_q ? '0 : c_q)]
			: mat_b_q[EW'(k) * EW'(DIM) + EW'(cd_q[(k == 0) ? 0 : k-1])];
		mmt_mac_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.word_in  (chain[k]),
			.a_val    (a_op),
			.b_val    (b_op),
			.word_out (chain[k+1])
		);
	end

	// Scale, saturate and hold the result word.
	logic signed [ACC_W-FRAC_W-1:0] scaled;
	logic signed [VAL_W-1:0]        sat;
	assign scaled = tail.acc[ACC_W-1:FRAC_W];
	always_comb begin
		if (scaled > (ACC_W-FRAC_W)'(32'sh7fffffff)) begin
			sat = 32'sh7fffffff;
		end else if (scaled < -(ACC_W-FRAC_W)'(33'sh080000000)) begin
			sat = 32'sh80000000;
		end else begin
			sat = scaled[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv) begin
			ovld_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.vld) begin
			res.out_row   <= tail.row;
			res.out_col   <= tail.col;
			res.out_value <= sat;
			res.out_last  <= tail.last;
		end
	end
	assign res.valid = ovld_q;

	// A command is never taken while a run is still in flight.
	a_no_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.ready) else $error("command taken during run");
	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.out_value)))
		else $error("result word dropped under stall");
	// Output other than a run's last word only appears while the run is active.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.out_last |-> busy_q) else $error("stray result word");

endmodule
